// ----- design/buddy_block_allocator_top_assert.svh -----
// assertion helpers shared by the allocator modules
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define BBA_ASSERT_NOW(lbl, clk_i, rst_i, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define BBA_ASSERT_NEXT(lbl, clk_i, rst_i, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/bba_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

  localparam int unsigned NODES_DEF = 32;
  localparam logic [4:0] TOTAL_ORDER_RST = 5'd10;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_COUNT = 2'd1;
  localparam logic [1:0] KIND_OWNER = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_NOFIT = 2'd1;
  localparam logic [1:0] STAT_NOMEM = 2'd2;

  typedef struct packed {
    logic        func;
    logic [15:0] owner_id;
    logic [30:0] request_size;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] value;
    logic [1:0]  status;
    logic        last;
  } rsp_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_P1_RD,
    S_P1_CHK,
    S_P2_RD,
    S_P2_CHK,
    S_FIT,
    S_SPLIT_A,
    S_SPLIT_B,
    S_ASSIGN,
    S_RESP,
    S_Q_CNT,
    S_Q_RD,
    S_Q_EMIT
  } ctl_state_t;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_ALLOC,
    OUT_COUNT,
    OUT_OWNER
  } out_sel_t;

  typedef struct packed {
    logic       init;
    logic       cap;
    logic       walk_start;
    logic       walk_step;
    logic       take_order;
    logic       split_a;
    logic       split_b;
    logic       own_wr;
    logic       set_st;
    logic [1:0] st;
    out_sel_t   out_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic hit_exact;
    logic hit_larger;
    logic walk_last;
    logic overflow;
    logic split_more;
    logic out_free;
  } dp_stat_t;

  // smallest order whose block holds size units, size 0 counts as 1
  function automatic logic [4:0] size_order(input logic [30:0] size);
    logic [30:0] m;
    logic [4:0]  r;
    m = size - 31'd1;
    r = '0;
    if (size > 31'd1) begin
      for (int i = 0; i < 31; i++) begin
        if (m[i]) begin
          r = 5'(i + 1);
        end
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/bba_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "buddy_block_allocator_top_assert.svh"

module bba_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic              req_valid,
  input  logic              req_func,
  output logic              req_stall,
  input  bba_pkg::dp_stat_t stat,
  output bba_pkg::dp_cmd_t  cmd
);
  import bba_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;

  assign req_stall = (state != S_IDLE) || cfg_wen;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_INIT: begin
        cmd.init = 1'b1;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid && !req_stall) begin
          cmd.cap = 1'b1;
          state_next = (req_func == FUNC_QUERY) ? S_Q_CNT : S_P1_RD;
        end
      end
      // first pass: exact size match
      S_P1_RD: begin
        cmd.walk_start = 1'b1;
        state_next = S_P1_CHK;
      end
      S_P1_CHK: begin
        if (stat.hit_exact) begin
          state_next = S_ASSIGN;
        end else if (stat.walk_last) begin
          state_next = S_P2_RD;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      // second pass: first larger free block
      S_P2_RD: begin
        cmd.walk_start = 1'b1;
        state_next = S_P2_CHK;
      end
      S_P2_CHK: begin
        if (stat.hit_larger) begin
          cmd.take_order = 1'b1;
          state_next = S_FIT;
        end else if (stat.walk_last) begin
          cmd.set_st = 1'b1;
          cmd.st = STAT_NOFIT;
          state_next = S_RESP;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_FIT: begin
        if (stat.overflow) begin
          cmd.set_st = 1'b1;
          cmd.st = STAT_NOMEM;
          state_next = S_RESP;
        end else begin
          state_next = S_SPLIT_A;
        end
      end
      S_SPLIT_A: begin
        cmd.split_a = 1'b1;
        state_next = S_SPLIT_B;
      end
      S_SPLIT_B: begin
        cmd.split_b = 1'b1;
        state_next = stat.split_more ? S_SPLIT_A : S_ASSIGN;
      end
      S_ASSIGN: begin
        cmd.own_wr = 1'b1;
        cmd.set_st = 1'b1;
        cmd.st = STAT_OK;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_sel = OUT_ALLOC;
          state_next = S_IDLE;
        end
      end
      S_Q_CNT: begin
        if (stat.out_free) begin
          cmd.out_sel = OUT_COUNT;
          state_next = S_Q_RD;
        end
      end
      S_Q_RD: begin
        cmd.walk_start = 1'b1;
        state_next = S_Q_EMIT;
      end
      S_Q_EMIT: begin
        if (stat.out_free) begin
          cmd.out_sel = OUT_OWNER;
          if (stat.walk_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.walk_step = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
    // a register write restarts the pool
    if (cfg_wen) begin
      state_next = S_INIT;
    end
  end

  `BBA_ASSERT_NOW(a_step_not_past_end, clk, rst, cmd.walk_step, !stat.walk_last, "walk stepped past list end")
  `BBA_ASSERT_NOW(a_split_needed, clk, rst, state == S_SPLIT_A, stat.split_more, "split of block already at wanted order")

endmodule

`default_nettype wire

// ----- design/bba_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "buddy_block_allocator_top_assert.svh"

module bba_dp #(
  parameter int unsigned NODES = bba_pkg::NODES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic [4:0]        cfg_data,
  input  bba_pkg::req_t     req,
  input  bba_pkg::dp_cmd_t  cmd,
  output bba_pkg::dp_stat_t stat,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output bba_pkg::rsp_t     rsp
);
  import bba_pkg::*;

  localparam int unsigned NW = $clog2(NODES);
  localparam int unsigned LW = NW + 1;
  localparam int unsigned CW = $clog2(NODES + 1);
  localparam int unsigned SW = CW + 6;
  localparam logic [LW-1:0] LINK_END = '1;
  localparam logic [LW-1:0] NODES_L = LW'(NODES);
  localparam logic [CW-1:0] NODES_C = CW'(NODES);
  localparam logic [SW-1:0] NODES_S = SW'(NODES);

  logic [4:0]    order_mem [NODES];
  logic [LW-1:0] link_mem  [NODES];
  logic [15:0]   owner_mem [NODES];

  logic [4:0]    rd_order;
  logic [LW-1:0] rd_link;
  logic [15:0]   rd_owner;

  logic [4:0]    total_order;
  logic [4:0]    want;
  logic [15:0]   owner_id;
  logic [NW-1:0] head;
  logic [CW-1:0] node_count;
  logic [NW-1:0] cur;
  logic [NW-1:0] pred;
  logic          has_pred;
  logic [CW-1:0] steps;
  logic [4:0]    split_order;
  logic [1:0]    alloc_st;

  logic [NW-1:0] new_idx;
  logic          rd_en;
  logic [NW-1:0] rd_addr;
  logic          ord_we;
  logic [NW-1:0] ord_addr;
  logic [4:0]    ord_data;
  logic          own_we;
  logic [NW-1:0] own_addr;
  logic [15:0]   own_data;
  logic          lnk_we;
  logic [NW-1:0] lnk_addr;
  logic [LW-1:0] lnk_data;
  logic [CW:0]   steps_inc;
  logic          out_load;
  rsp_t          rsp_next;

  assign new_idx = node_count[NW-1:0];

  // read port, one list node per cycle unless a stalled output holds the query walk
  assign rd_en   = cmd.walk_start || cmd.walk_step;
  assign rd_addr = cmd.walk_start ? head : rd_link[NW-1:0];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_order <= order_mem[rd_addr];
      rd_link  <= link_mem[rd_addr];
      rd_owner <= owner_mem[rd_addr];
    end
  end

  // write ports
  always_comb begin
    ord_we   = cmd.init || cmd.split_a || cmd.split_b;
    ord_addr = cmd.init ? '0 : (cmd.split_a ? cur : new_idx);
    ord_data = cmd.init ? total_order : (cmd.split_a ? split_order - 5'd1 : split_order);
    own_we   = cmd.init || cmd.split_b || cmd.own_wr;
    own_addr = cmd.init ? '0 : (cmd.split_b ? new_idx : cur);
    own_data = cmd.own_wr ? owner_id : 16'd0;
    lnk_we   = cmd.init || cmd.split_b || (cmd.split_a && has_pred);
    lnk_addr = cmd.init ? '0 : (cmd.split_a ? pred : new_idx);
    lnk_data = cmd.init ? LINK_END : (cmd.split_a ? LW'(new_idx) : LW'(cur));
  end

  always_ff @(posedge clk) begin
    if (ord_we) begin
      order_mem[ord_addr] <= ord_data;
    end
    if (own_we) begin
      owner_mem[own_addr] <= own_data;
    end
    if (lnk_we) begin
      link_mem[lnk_addr] <= lnk_data;
    end
  end

  // pool and walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      total_order <= TOTAL_ORDER_RST;
      node_count  <= CW'(1);
      head        <= '0;
    end else begin
      if (cfg_wen) begin
        total_order <= cfg_data;
      end
      if (cmd.init) begin
        node_count <= CW'(1);
        head       <= '0;
      end
      if (cmd.split_a && !has_pred) begin
        head <= new_idx;
      end
      if (cmd.split_b) begin
        node_count <= node_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      want     <= size_order(req.request_size);
      owner_id <= req.owner_id;
    end
    if (cmd.walk_start) begin
      cur      <= head;
      steps    <= '0;
      has_pred <= 1'b0;
    end
    if (cmd.walk_step) begin
      pred     <= cur;
      has_pred <= 1'b1;
      cur      <= rd_link[NW-1:0];
      steps    <= steps + CW'(1);
    end
    if (cmd.take_order) begin
      split_order <= rd_order;
    end
    if (cmd.split_a) begin
      split_order <= split_order - 5'd1;
    end
    if (cmd.split_b) begin
      cur <= new_idx;
    end
    if (cmd.set_st) begin
      alloc_st <= cmd.st;
    end
  end

  // status
  assign steps_inc = {1'b0, steps} + (CW + 1)'(1);

  always_comb begin
    stat.hit_exact  = (rd_order == want) && (rd_owner == 16'd0);
    stat.hit_larger = (rd_order > want) && (rd_owner == 16'd0);
    stat.walk_last  = (steps_inc >= {1'b0, node_count}) || (rd_link >= NODES_L);
    stat.overflow   = (SW'(node_count) + SW'(split_order - want)) > NODES_S;
    stat.split_more = split_order > want;
    stat.out_free   = !rsp_valid || !rsp_stall;
  end

  // output register
  assign out_load = (cmd.out_sel != OUT_NONE);

  always_comb begin
    rsp_next = '0;
    case (cmd.out_sel)
      OUT_ALLOC: begin
        rsp_next.kind   = KIND_ALLOC;
        rsp_next.status = alloc_st;
        rsp_next.last   = 1'b1;
      end
      OUT_COUNT: begin
        rsp_next.kind   = KIND_COUNT;
        rsp_next.value  = 16'(node_count);
        rsp_next.status = STAT_OK;
        rsp_next.last   = (node_count == '0);
      end
      OUT_OWNER: begin
        rsp_next.kind   = KIND_OWNER;
        rsp_next.value  = rd_owner;
        rsp_next.status = STAT_OK;
        rsp_next.last   = stat.walk_last;
      end
      default: begin
        rsp_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp <= rsp_next;
    end
  end

  `BBA_ASSERT_NOW(a_load_when_free, clk, rst, out_load, stat.out_free, "output register overwritten")
  `BBA_ASSERT_NOW(a_count_range, clk, rst, 1'b1, (node_count != '0) && (node_count <= NODES_C), "node count out of range")
  `BBA_ASSERT_NEXT(a_split_grows, clk, rst, cmd.split_b, node_count == $past(node_count) + CW'(1), "split did not add a node")

endmodule

`default_nettype wire

// ----- design/buddy_block_allocator_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// allocate: a first list walk looks for an exact fit; otherwise a second walk takes the first
//   larger free block and splits it down to the wanted order (one node per cycle on each list walk)
// query: node_count + 1 items, the count first, then owners one per cycle unless the output stalls
// next item is taken once the previous one has loaded its last result into the output register
// rst is synchronous: total_order 10, pool one free block; an init state follows reset and
//   every total_order write, during which req_stall is high

module buddy_block_allocator_top #(
  parameter int unsigned NODES = bba_pkg::NODES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  // total_order register, any write restarts the pool
  input  logic          cfg_wen,
  input  logic [4:0]    cfg_data,
  // request channel
  input  logic          req_valid,
  output logic          req_stall,
  input  bba_pkg::req_t req,
  // result channel
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output bba_pkg::rsp_t rsp
);
  import bba_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: two list passes for allocate, split loop, query emitter
  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .req_valid (req_valid),
    .req_func  (req.func),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // node store, walk pointers, pool counters and the result register
  bba_dp #(
    .NODES (NODES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire
